// ===== rtl/bcc_pkg.sv =====
// Shared types, constants and register codes for the button click classifier.
package bcc_pkg;

  localparam int unsigned BUTTON_BITS = 16;
  localparam int unsigned MASK_W      = 16;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  // Only the low BUTTON_BITS bits of a poll take part.
  localparam logic [MASK_W-1:0] POLL_MASK =
    (BUTTON_BITS >= MASK_W) ? {MASK_W{1'b1}} :
    MASK_W'((64'd1 << BUTTON_BITS) - 64'd1);

  localparam logic [CFG_W-1:0] DEBOUNCE_RST     = CFG_W'(30);
  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = CFG_W'(3000);
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = CFG_W'(150);

  typedef logic [MASK_W-1:0] mask_t;
  typedef logic [TIME_W-1:0] time_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_LONG_PRESS   = 2'd1,
    REG_DOUBLE_CLICK = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLICK_SINGLE = 2'd0,
    CLICK_DOUBLE = 2'd1,
    CLICK_LONG   = 2'd2
  } click_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] double_click_ms;
  } cfg_t;

  typedef struct packed {
    mask_t      stable_mask;
    mask_t      recorded_mask;
    time_t      reference_time;
    logic [1:0] click_count;
    logic       long_flag;
  } state_t;

  typedef struct packed {
    logic   report;
    mask_t  event_buttons;
    click_t click_type;
  } result_t;

endpackage

// ===== rtl/bcc_in_if.sv =====
// Poll request channel: button mask and millisecond timestamp.
interface bcc_in_if import bcc_pkg::*;;
  logic  valid;
  logic  ready;
  mask_t button_mask;
  time_t now_ms;

  modport source (output valid, output button_mask, output now_ms, input ready);
  modport sink (input valid, input button_mask, input now_ms, output ready);
endinterface

// ===== rtl/bcc_out_if.sv =====
// Click event channel: recorded button mask and click type.
interface bcc_out_if import bcc_pkg::*;;
  logic       valid;
  logic       ready;
  mask_t      event_buttons;
  logic [1:0] click_type;

  modport source (output valid, output event_buttons, output click_type, input ready);
  modport sink (input valid, input event_buttons, input click_type, output ready);
endinterface

// ===== rtl/bcc_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface bcc_cfg_if import bcc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bcc_cfg.sv =====
// Configuration register file for the timing thresholds.
module bcc_cfg import bcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bcc_cfg_if.sink   cfg_ch,
  output cfg_t      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DEBOUNCE:     cfg_nxt.debounce_ms     = cfg_ch.data;
        REG_LONG_PRESS:   cfg_nxt.long_press_ms   = cfg_ch.data;
        REG_DOUBLE_CLICK: cfg_nxt.double_click_ms = cfg_ch.data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms     <= DEBOUNCE_RST;
      cfg_r.long_press_ms   <= LONG_PRESS_RST;
      cfg_r.double_click_ms <= DOUBLE_CLICK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/bcc_step.sv =====
// Per-poll debounce, press tracking and click classification logic.
module bcc_step import bcc_pkg::*; (
  input  cfg_t    cfg,
  input  state_t  st,
  input  mask_t   button_mask,
  input  time_t   now_ms,
  output state_t  st_nxt,
  output result_t res
);

  mask_t      mask;
  time_t      elapsed;
  time_t      quiet;
  logic       changed;
  logic [1:0] cnt_inc;
  state_t     mid;

  assign mask    = button_mask & POLL_MASK;
  assign elapsed = now_ms - st.reference_time;
  assign changed = (mask != st.stable_mask) &&
                   (TIME_W'(cfg.debounce_ms) < elapsed);
  assign cnt_inc = (st.click_count == 2'd3) ? 2'd3 : st.click_count + 2'd1;

  always_comb begin
    mid = st;
    if (changed) begin
      if (mask > st.stable_mask) begin
        mid.reference_time = now_ms;
        mid.stable_mask    = mask;
        mid.recorded_mask  = mask;
      end else if (mask == '0) begin
        // Release: count the click and judge the hold length.
        mid.click_count = cnt_inc;
        mid.stable_mask = '0;
        if (TIME_W'(cfg.long_press_ms) <= elapsed) begin
          mid.long_flag      = 1'b1;
          mid.reference_time = '0;
        end else begin
          mid.long_flag      = 1'b0;
          mid.reference_time = (cnt_inc > 2'd1) ? '0 : now_ms;
        end
      end else begin
        mid.reference_time = now_ms;
      end
    end
  end

  assign quiet = now_ms - mid.reference_time;

  always_comb begin
    st_nxt            = mid;
    res.report        = (TIME_W'(cfg.double_click_ms) < quiet) && (mid.click_count != 2'd0);
    res.event_buttons = mid.recorded_mask;
    if (mid.long_flag) begin
      res.click_type = CLICK_LONG;
    end else if (mid.click_count == 2'd2) begin
      res.click_type = CLICK_DOUBLE;
    end else begin
      res.click_type = CLICK_SINGLE;
    end
    if (res.report) begin
      st_nxt.click_count    = 2'd0;
      st_nxt.recorded_mask  = '0;
      st_nxt.reference_time = now_ms;
    end
  end

endmodule

// ===== rtl/button_click_classifier.sv =====
// A poll accepted into the poll register is classified by the step logic, and its click
// event is registered in the event register, which drives the event port.
// Throughput: one poll per cycle while the event port is not stalled; the state update
// is a single pass of subtract and compare logic between the poll and event registers.
// While an event waits to be taken, a new poll can enter only an empty poll register.
// Reset (synchronous, rst_n low) clears all press state and restores the
// default thresholds of 30, 3000 and 150 ms.
module button_click_classifier import bcc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  bcc_in_if.sink     in_ch,
  bcc_out_if.source  out_ch,
  bcc_cfg_if.sink    cfg_ch
);

  cfg_t    cfg;
  state_t  st_r;
  state_t  st_nxt;
  result_t res;

  logic    in_v_r;
  mask_t   in_mask_r;
  time_t   in_now_r;
  logic    out_v_r;
  mask_t   out_mask_r;
  click_t  out_type_r;
  logic    adv;

  bcc_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  bcc_step u_step (
    .cfg         (cfg),
    .st          (st_r),
    .button_mask (in_mask_r),
    .now_ms      (in_now_r),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  // The poll register moves on whenever the event register has room.
  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= '0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (adv) begin
        out_v_r <= in_v_r && res.report;
        if (in_v_r) begin
          st_r <= st_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_mask_r <= in_ch.button_mask;
      in_now_r  <= in_ch.now_ms;
    end
    if (adv && in_v_r) begin
      out_mask_r <= res.event_buttons;
      out_type_r <= res.click_type;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.event_buttons = out_mask_r;
  assign out_ch.click_type    = out_type_r;

endmodule

// ===== rtl/bcc_checker.sv =====
// Port-level checks for the button click classifier, bound to the top level.
module bcc_checker import bcc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input mask_t      event_buttons,
  input logic [1:0] click_type
);

  // A pending event holds steady until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_buttons) && $stable(click_type))
    else $error("event changed while stalled");

  // With no event waiting, the poll side is never blocked.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("poll request refused with empty event register");

  // A new event is always caused by an earlier poll request.
  a_event_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("event without a preceding poll request");

  // Reset leaves no event pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("event pending after reset");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .event_buttons (out_ch.event_buttons),
  .click_type    (out_ch.click_type)
);
